// ===== sv/str_pkg.sv =====
// ----------------------------------------------------------------------------
// str_pkg
// Shared types and constants for the separable triangle resampler.
// ----------------------------------------------------------------------------
package str_pkg;

    localparam int unsigned WeightWidth = 23;
    localparam int unsigned CountWidth  = 7;
    localparam int unsigned DimWidth    = 9;
    localparam int unsigned RegIdxWidth = 2;
    localparam int unsigned MaxDim      = 256;
    localparam int unsigned MaxTaps     = 32;

    typedef enum logic [2:0] {
        OP_PIXEL   = 3'd0,
        OP_HWEIGHT = 3'd1,
        OP_VWEIGHT = 3'd2,
        OP_HSPAN   = 3'd3,
        OP_VSPAN   = 3'd4,
        OP_HCOMP   = 3'd5,
        OP_VCOMP   = 3'd6,
        OP_NONE    = 3'd7
    } t_op;

    localparam logic [RegIdxWidth-1:0] REG_SRC_W = 2'd0;
    localparam logic [RegIdxWidth-1:0] REG_SRC_H = 2'd1;
    localparam logic [RegIdxWidth-1:0] REG_DST_W = 2'd2;
    localparam logic [RegIdxWidth-1:0] REG_DST_H = 2'd3;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [4:0]  tap;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [22:0] weight;
        logic [7:0]  span_start;
        logic [6:0]  span_count;
    } t_in;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] out_col;
        logic [7:0] out_row;
    } t_out;

    // decoded command handed from front to back
    typedef struct packed {
        t_op         op;
        logic [7:0]  col;
        logic [7:0]  row;
        logic [4:0]  tap;
        logic [23:0] rgb;
        logic [22:0] weight;
        logic [7:0]  start;
        logic [6:0]  count;
        logic        copy;
    } t_cmd;

endpackage

// ===== sv/separable_triangle_resampler.sv =====
// ----------------------------------------------------------------------------
// separable_triangle_resampler
// Two-pass fixed-point RGB resampler with loadable spans and tap weights.
//
//   channel | direction | handshake                 | word
//   in      | input     | i_valid / o_ready         | str_pkg::t_in
//   out     | output    | o_valid / i_ready         | str_pkg::t_out
//   cfg     | input     | i_cfg_valid / o_cfg_ready | index + 9-bit data
//
// Stores and table writes retire from the idle state. A compute word
// runs a span read, one tap per cycle through the weight and pixel RAMs,
// a drain step and the writeback. A same-size copy reads the source
// pixel into the output register. A two-entry queue lets words be
// taken while the back end computes; the output register holds one result.
// Reset is synchronous; memories are not cleared.
// ----------------------------------------------------------------------------
module separable_triangle_resampler #(
    parameter int unsigned FRAC_BITS = 22
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  str_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output str_pkg::t_out o_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [8:0]    i_cfg_data
);
    logic [8:0] r_src_w, r_src_h, r_dst_w, r_dst_h;
    logic          w_cmd_valid, w_cmd_pop, w_same;
    str_pkg::t_cmd w_cmd;

    assign o_cfg_ready = 1'b1;
    assign w_same = (r_dst_w == r_src_w) && (r_dst_h == r_src_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_w <= 9'd256;
            r_src_h <= 9'd256;
            r_dst_w <= 9'd256;
            r_dst_h <= 9'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                str_pkg::REG_SRC_W: r_src_w <= i_cfg_data;
                str_pkg::REG_SRC_H: r_src_h <= i_cfg_data;
                str_pkg::REG_DST_W: r_dst_w <= i_cfg_data;
                str_pkg::REG_DST_H: r_dst_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    str_front #(.QDEPTH(2)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_data(i_data), .i_same(w_same), .o_cmd_valid(w_cmd_valid),
        .i_cmd_pop(w_cmd_pop), .o_cmd(w_cmd));

    str_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd_valid(w_cmd_valid),
        .o_cmd_pop(w_cmd_pop), .i_cmd(w_cmd), .i_src_w(r_src_w), .i_src_h(r_src_h),
        .o_valid(o_valid), .i_ready(i_ready), .o_data(o_data));

    a_pop_needs_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd_pop |-> w_cmd_valid) else $error("pop from empty queue");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_data)))
        else $error("result dropped while stalled");
endmodule

// ===== sv/str_ram.sv =====
// ----------------------------------------------------------------------------
// str_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module str_ram #(
    parameter int unsigned WIDTH = 24,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/str_front.sv =====
// ----------------------------------------------------------------------------
// str_front
// Accepts input words, saturates span counts, flags same-size copies, and
// pushes decoded commands into a short queue.
// ----------------------------------------------------------------------------
module str_front #(
    parameter int unsigned QDEPTH   = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  str_pkg::t_in      i_data,
    input  logic              i_same,
    output logic              o_cmd_valid,
    input  logic              i_cmd_pop,
    output str_pkg::t_cmd     o_cmd
);
    localparam int unsigned QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    str_pkg::t_cmd r_q [QDEPTH];
    logic [QAW-1:0] r_wp, r_rp;
    logic [QAW:0]   r_cnt;
    str_pkg::t_cmd  w_cmd;
    logic           w_push;

    always_comb begin
        w_cmd.op     = str_pkg::t_op'(i_data.operation);
        w_cmd.col    = i_data.col;
        w_cmd.row    = i_data.row;
        w_cmd.tap    = i_data.tap;
        w_cmd.rgb    = {i_data.red_in, i_data.green_in, i_data.blue_in};
        w_cmd.weight = i_data.weight;
        w_cmd.start  = i_data.span_start;
        w_cmd.count  = (32'(i_data.span_count) > str_pkg::MaxTaps) ?
                       7'(str_pkg::MaxTaps) : i_data.span_count;
        w_cmd.copy   = i_same;
    end

    assign o_ready     = (r_cnt != (QAW+1)'(QDEPTH));
    assign w_push      = i_valid && o_ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (32'(r_wp) == QDEPTH-1) ? '0 : r_wp + 1'b1;
            end
            if (i_cmd_pop) begin
                r_rp <= (32'(r_rp) == QDEPTH-1) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(w_push) - (QAW+1)'(i_cmd_pop);
        end
    end
endmodule

// ===== sv/str_back.sv =====
// ----------------------------------------------------------------------------
// str_back
// Executes commands: table and image stores, same-size copies, and a one-tap-per-cycle
// multiply-accumulate sequencer for the horizontal and vertical passes.
// ----------------------------------------------------------------------------
module str_back #(
    parameter int unsigned FRAC_BITS = 22
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cmd_valid,
    output logic                 o_cmd_pop,
    input  str_pkg::t_cmd        i_cmd,
    input  logic [8:0]           i_src_w,
    input  logic [8:0]           i_src_h,
    output logic                 o_valid,
    input  logic                 i_ready,
    output str_pkg::t_out        o_data
);
    localparam int unsigned DW   = $clog2(str_pkg::MaxDim);
    localparam int unsigned TW   = $clog2(str_pkg::MaxTaps);
    localparam int unsigned PAW  = 2 * DW;
    localparam int unsigned WAW  = DW + TW;
    localparam int unsigned ACCW = 8 + 23 + 7 + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_TAP  = 6'b000010,
        S_MAC  = 6'b000100,
        S_DONE = 6'b001000,
        S_COPY = 6'b010000,
        S_CRD  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    str_pkg::t_cmd r_cmd;
    logic [6:0]    r_i;
    logic          r_live;
    logic [ACCW-1:0] r_a0, r_a1, r_a2;
    logic [23:0]   r_p;
    logic [22:0]   r_w;
    logic          r_pv;
    logic          r_ov;
    str_pkg::t_out r_od;

    logic w_horiz;
    logic [8:0] w_idx;
    logic w_in_rng, w_in_dim;
    logic [15:0] w_span_h, w_span_v, w_span;
    logic [7:0]  w_start;
    logic [6:0]  w_cnt;

    // memory wires
    logic            w_src_we, w_int_we, w_hw_we, w_vw_we, w_hs_we, w_vs_we;
    logic [PAW-1:0]  w_src_wa, w_src_ra, w_int_wa, w_int_ra;
    logic [23:0]     w_src_rd, w_int_rd, w_int_wd;
    logic [WAW-1:0]  w_hw_wa, w_vw_wa, w_wt_ra;
    logic [22:0]     w_hw_rd, w_vw_rd;
    logic [DW-1:0]   w_hs_wa, w_vs_wa, w_hs_ra, w_vs_ra;
    logic [14:0]     w_sp_wd, w_hs_rd, w_vs_rd;
    logic            w_out_free;

    assign w_out_free = !r_ov || i_ready;
    assign w_horiz    = (r_cmd.op == str_pkg::OP_HCOMP);

    // span read data is valid in the cycle after command capture (state S_TAP), where r_start and r_cnt latch it
    assign w_span_h = {1'b0, w_hs_rd};
    assign w_span_v = {1'b0, w_vs_rd};
    assign w_span   = w_horiz ? w_span_h : w_span_v;
    assign w_start  = w_span[7:0];
    assign w_cnt    = w_span[14:8];

    logic [7:0] r_start;
    logic [6:0] r_cnt;

    assign w_idx    = 9'(r_start) + 9'(r_i);
    assign w_in_dim = (32'(w_idx) < str_pkg::MaxDim);
    assign w_in_rng = (w_idx < (w_horiz ? i_src_w : i_src_h)) && w_in_dim;

    // ------------------------------------------------------------ writes
    always_comb begin
        logic accept;
        accept   = (r_state == S_IDLE) && i_cmd_valid;
        w_src_we = accept && (i_cmd.op == str_pkg::OP_PIXEL);
        w_hw_we  = accept && (i_cmd.op == str_pkg::OP_HWEIGHT);
        w_vw_we  = accept && (i_cmd.op == str_pkg::OP_VWEIGHT);
        w_hs_we  = accept && (i_cmd.op == str_pkg::OP_HSPAN);
        w_vs_we  = accept && (i_cmd.op == str_pkg::OP_VSPAN);
        w_src_wa = PAW'({i_cmd.row, i_cmd.col});
        w_hw_wa  = WAW'({i_cmd.col, i_cmd.tap});
        w_vw_wa  = WAW'({i_cmd.row, i_cmd.tap});
        w_hs_wa  = DW'(i_cmd.col);
        w_vs_wa  = DW'(i_cmd.row);
        w_sp_wd  = {i_cmd.count, i_cmd.start};
    end

    // ------------------------------------------------------------ reads
    assign w_hs_ra  = (r_state == S_IDLE) ? DW'(i_cmd.col) : DW'(r_cmd.col);
    assign w_vs_ra  = (r_state == S_IDLE) ? DW'(i_cmd.row) : DW'(r_cmd.row);
    assign w_src_ra = (r_state == S_IDLE) ? PAW'({i_cmd.row, i_cmd.col}) :
                      PAW'({r_cmd.row, r_cmd.col});
    assign w_int_ra = PAW'({w_idx[7:0], r_cmd.col});
    assign w_wt_ra  = WAW'({(w_horiz ? r_cmd.col : r_cmd.row), r_i[4:0]});

    function automatic logic [7:0] clip(input logic [ACCW-1:0] a);
        logic [ACCW-1:0] v;
        v = a >> FRAC_BITS;
        return (v > ACCW'(255)) ? 8'd255 : v[7:0];
    endfunction

    assign w_int_we = (r_state == S_DONE) && w_horiz;
    assign w_int_wa = PAW'({r_cmd.row, r_cmd.col});
    assign w_int_wd = {clip(r_a0), clip(r_a1), clip(r_a2)};

    logic [22:0] w_wrd;
    logic [23:0] w_prd;
    assign w_wrd = w_horiz ? w_hw_rd : w_vw_rd;
    assign w_prd = w_horiz ? w_src_rd : w_int_rd;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_cmd_valid) begin
                if (i_cmd.op == str_pkg::OP_HCOMP ||
                    (i_cmd.op == str_pkg::OP_VCOMP && !i_cmd.copy)) begin
                    n_state = S_TAP;
                end else if (i_cmd.op == str_pkg::OP_VCOMP) begin
                    n_state = S_CRD;
                end
            end
            S_TAP:  n_state = S_MAC;
            S_MAC:  if (r_i >= r_cnt && !r_pv) n_state = S_DONE;
            S_DONE: if (w_horiz || w_out_free) n_state = S_IDLE;
            S_CRD:  n_state = S_COPY;
            S_COPY: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_TAP) begin
            r_start <= w_start;
            r_cnt   <= w_cnt;
            r_i     <= '0;
            r_pv    <= 1'b0;
            r_a0    <= ACCW'(1) << (FRAC_BITS - 1);
            r_a1    <= ACCW'(1) << (FRAC_BITS - 1);
            r_a2    <= ACCW'(1) << (FRAC_BITS - 1);
        end else if (r_state == S_MAC) begin
            // issue read for tap r_i, consume previous one
            r_live <= (r_i < r_cnt) && w_in_rng;
            r_pv   <= (r_i < r_cnt);
            if (r_i < r_cnt) begin
                r_i <= r_i + 1'b1;
            end
            if (r_pv && r_live) begin
                r_a0 <= r_a0 + ACCW'(w_prd[23:16]) * ACCW'(w_wrd);
                r_a1 <= r_a1 + ACCW'(w_prd[15:8]) * ACCW'(w_wrd);
                r_a2 <= r_a2 + ACCW'(w_prd[7:0]) * ACCW'(w_wrd);
            end
        end
        if (r_state == S_DONE && !w_horiz && w_out_free) begin
            r_od <= '{red_out: clip(r_a0), green_out: clip(r_a1),
                      blue_out: clip(r_a2), out_col: r_cmd.col, out_row: r_cmd.row};
        end else if (r_state == S_COPY && w_out_free) begin
            r_od <= '{red_out: w_src_rd[23:16], green_out: w_src_rd[15:8],
                      blue_out: w_src_rd[7:0], out_col: r_cmd.col, out_row: r_cmd.row};
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_DONE && !w_horiz && w_out_free) ||
                (r_state == S_COPY && w_out_free)) begin
                r_ov <= 1'b1;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

    logic [PAW-1:0] w_src_raddr;
    assign w_src_raddr = (r_state == S_MAC) ? PAW'({r_cmd.row, w_idx[7:0]}) :
                         w_src_ra;

    str_ram #(.WIDTH(24), .DEPTH(str_pkg::MaxDim*str_pkg::MaxDim)) u_src (
        .i_clk(i_clk), .i_we(w_src_we), .i_waddr(w_src_wa),
        .i_wdata(i_cmd.rgb), .i_raddr(w_src_raddr), .o_rdata(w_src_rd));
    str_ram #(.WIDTH(24), .DEPTH(str_pkg::MaxDim*str_pkg::MaxDim)) u_int (
        .i_clk(i_clk), .i_we(w_int_we), .i_waddr(w_int_wa),
        .i_wdata(w_int_wd), .i_raddr(w_int_ra), .o_rdata(w_int_rd));
    str_ram #(.WIDTH(23), .DEPTH(str_pkg::MaxDim*str_pkg::MaxTaps)) u_hw (
        .i_clk(i_clk), .i_we(w_hw_we), .i_waddr(w_hw_wa),
        .i_wdata(i_cmd.weight), .i_raddr(w_wt_ra), .o_rdata(w_hw_rd));
    str_ram #(.WIDTH(23), .DEPTH(str_pkg::MaxDim*str_pkg::MaxTaps)) u_vw (
        .i_clk(i_clk), .i_we(w_vw_we), .i_waddr(w_vw_wa),
        .i_wdata(i_cmd.weight), .i_raddr(w_wt_ra), .o_rdata(w_vw_rd));
    str_ram #(.WIDTH(15), .DEPTH(str_pkg::MaxDim)) u_hs (
        .i_clk(i_clk), .i_we(w_hs_we), .i_waddr(w_hs_wa),
        .i_wdata(w_sp_wd), .i_raddr(w_hs_ra), .o_rdata(w_hs_rd));
    str_ram #(.WIDTH(15), .DEPTH(str_pkg::MaxDim)) u_vs (
        .i_clk(i_clk), .i_we(w_vs_we), .i_waddr(w_vs_wa),
        .i_wdata(w_sp_wd), .i_raddr(w_vs_ra), .o_rdata(w_vs_rd));
endmodule
